// ----- hdl/dec_pkg.sv -----
// Shared types and constants for the debounced event counter.
// Used by dec_regs, dec_core, the top level and its checker; no dependencies.
package dec_pkg;

  localparam int unsigned NUM_SOURCES = 3;
  localparam int unsigned SRC_W       = 2;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_W      = 4;

  // item opcodes
  localparam logic [OP_W-1:0] OP_EVENT     = 2'd0;
  localparam logic [OP_W-1:0] OP_CLR_COUNT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR_TIME  = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_DELAY0 = 2'd0;
  localparam logic [1:0] REG_DELAY1 = 2'd1;
  localparam logic [1:0] REG_DELAY2 = 2'd2;

  localparam logic [DATA_W-1:0] DELAY0_RESET = 32'd50;
  localparam logic [DATA_W-1:0] DELAY1_RESET = 32'd200;
  localparam logic [DATA_W-1:0] DELAY2_RESET = 32'd50;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [SRC_W-1:0]  source;
    logic [DATA_W-1:0] now_tick;
  } dec_in_t;

  typedef struct packed {
    logic              counted;
    logic [DATA_W-1:0] event_count;
    logic [DATA_W-1:0] last_time;
  } dec_out_t;

  typedef logic [NUM_SOURCES-1:0][DATA_W-1:0] dec_delays_t;

endpackage

// ----- hdl/debounced_event_counter.sv -----
// Debounced event counter: input register, update core and result register.
// Depends on dec_pkg, dec_regs and dec_core.
//
// Usage:
//   Items (opcode, source, now_tick) enter on item/item_valid/item_stall; a
//   transfer happens at a clock edge with item_valid high and item_stall low.
//   Each item yields exactly one result (counted, event_count, last_time) on
//   result/result_valid/result_stall, in item order.
//   Each item passes through the input register, and the update then feeds the
//   result register, which loads it unless a stalled result is held there.
//   Throughput is one item per cycle while the result side is not stalled;
//   the subtract, compare and increment lie between the input and result registers.
//   When result_stall is high the result holds and the block keeps one more
//   item in its input register; item_stall rises only when both are full.
//   Synchronous reset clears counters, timestamps, the press flag and both
//   valid flags and restores the delay registers to 50, 200 and 50 ticks.
//   Delay registers are to be written over the APB-style port only while no
//   item is in flight, which the block does not enforce; pready is always high.
module debounced_event_counter
  import dec_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  dec_in_t           item,
  output logic              result_valid,
  input  logic              result_stall,
  output dec_out_t          result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  dec_delays_t delays;
  dec_in_t     item_q;
  logic        item_q_valid;
  dec_out_t    core_result;
  logic        out_load;
  logic        fire;

  dec_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .delays  (delays)
  );

  dec_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item_q),
    .delays (delays),
    .result (core_result)
  );

  assign out_load   = !result_valid || !result_stall;
  assign fire       = item_q_valid && out_load;
  assign item_stall = item_q_valid && !out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  // hold the input register while the result side is full
  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= item_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= core_result;
    end
  end

endmodule

// ----- hdl/dec_regs.sv -----
// Configuration registers: per-source minimum intervals behind an APB-style port.
// Depends on dec_pkg.
module dec_regs
  import dec_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output dec_delays_t       delays
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delays[0] <= DELAY0_RESET;
      delays[1] <= DELAY1_RESET;
      delays[2] <= DELAY2_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_DELAY0: delays[0] <= pwdata;
        REG_DELAY1: delays[1] <= pwdata;
        REG_DELAY2: delays[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_DELAY0: prdata = delays[0];
      REG_DELAY1: prdata = delays[1];
      REG_DELAY2: prdata = delays[2];
      default:    prdata = '0;
    endcase
  end

endmodule

// ----- hdl/dec_core.sv -----
// Per-source counters, timestamps and press flag, with the single-pass update logic.
// Depends on dec_pkg.
module dec_core
  import dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  dec_in_t     item,
  input  dec_delays_t delays,
  output dec_out_t    result
);

  logic [NUM_SOURCES-1:0][DATA_W-1:0] counters;
  logic [NUM_SOURCES-1:0][DATA_W-1:0] times;
  logic                               pressed;

  logic              src_ok;
  logic [DATA_W-1:0] cur_count;
  logic [DATA_W-1:0] cur_time;
  logic [DATA_W-1:0] cur_delay;
  logic [DATA_W-1:0] elapsed;
  logic              passed;
  logic [DATA_W-1:0] count_next;
  logic [DATA_W-1:0] time_next;
  logic              pressed_next;
  logic              counted;

  assign src_ok = item.source < SRC_W'(NUM_SOURCES);

  always_comb begin
    cur_count = '0;
    cur_time  = '0;
    cur_delay = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (item.source == SRC_W'(i)) begin
        cur_count = counters[i];
        cur_time  = times[i];
        cur_delay = delays[i];
      end
    end
  end

  // wrap-around elapsed time; equal to the delay does not qualify
  assign elapsed = item.now_tick - cur_time;
  assign passed  = elapsed > cur_delay;

  always_comb begin
    count_next   = cur_count;
    time_next    = cur_time;
    pressed_next = pressed;
    counted      = 1'b0;
    case (item.opcode)
      OP_EVENT: begin
        if (item.source == '0) begin
          // source 0 alternates: stamp on press, qualify on release
          if (!pressed) begin
            time_next    = item.now_tick;
            pressed_next = 1'b1;
          end else begin
            if (passed) begin
              count_next = cur_count + 1'b1;
              counted    = 1'b1;
            end
            pressed_next = 1'b0;
          end
        end else if (passed) begin
          count_next = cur_count + 1'b1;
          time_next  = item.now_tick;
          counted    = 1'b1;
        end
      end
      OP_CLR_COUNT: count_next = '0;
      OP_CLR_TIME:  time_next  = '0;
      default: ;
    endcase
  end

  always_comb begin
    if (src_ok) begin
      result.counted     = counted;
      result.event_count = count_next;
      result.last_time   = time_next;
    end else begin
      result = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counters <= '0;
      times    <= '0;
      pressed  <= 1'b0;
    end else if (fire && src_ok) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        if (item.source == SRC_W'(i)) begin
          counters[i] <= count_next;
          times[i]    <= time_next;
        end
      end
      pressed <= pressed_next;
    end
  end

endmodule

// ----- hdl/dec_checker.sv -----
// Port-level checks for the debounced event counter, bound to the top level.
// Depends on dec_pkg and debounced_event_counter.
module dec_checker
  import dec_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     item_valid,
  input logic     item_stall,
  input logic     result_valid,
  input logic     result_stall,
  input dec_out_t result,
  input logic     pready
);

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid set after reset");

  // a stalled result holds its value
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // the input side only backs up when the result side is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("item_stall without a stalled result");

  // an accepted item loads the result register from the input register when unblocked
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) ##1 !result_stall |=> result_valid)
    else $error("accepted item did not produce a result");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind debounced_event_counter dec_checker u_dec_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .pready       (pready)
);
